@@ rtl/jtp_pkg.sv @@
`timescale 1ns / 1ps

package jtp_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    // Result kinds.
    localparam logic [1:0] OUT_TX     = 2'd0;
    localparam logic [1:0] OUT_CHUNK  = 2'd1;
    localparam logic [1:0] OUT_STATUS = 2'd2;

    // Session end status codes.
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_TIMEOUT = 1'b1;

    // Connection-management control bytes.
    localparam logic [7:0] CTL_RTS = 8'h10;
    localparam logic [7:0] CTL_CTS = 8'h11;
    localparam logic [7:0] CTL_ACK = 8'h13;
    localparam logic [7:0] RESERVED_BYTE = 8'hFF;

    // Parameter group numbers of the transport protocol.
    localparam logic [17:0] PGN_CM = 18'h0EC00;
    localparam logic [17:0] PGN_DT = 18'h0EB00;
    localparam logic [7:0]  PF_CM  = 8'hEC;
    localparam logic [7:0]  PF_PDU2_MIN = 8'd240;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_REPLY_PRIORITY = 2'd0;
    localparam logic [1:0] CFG_LOCAL_ADDRESS  = 2'd1;
    localparam logic [1:0] CFG_PEER_ADDRESS   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd3;

    localparam logic [2:0]  PRIORITY_RESET = 3'd7;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [28:0] can_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [28:0] tx_can_id;
        logic [63:0] payload;
        logic [15:0] chunk_offset;
        logic [2:0]  chunk_bytes;
        logic [17:0] msg_pgn;
        logic [15:0] msg_len;
        logic        status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  reply_priority;
        logic [7:0]  local_address;
        logic [7:0]  peer_address;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // Results caused by one input item, first in slot 0.
    typedef struct packed {
        logic [1:0]           cnt;
        t_out_item [2:0]      res;
    } t_group;

    // Transmit frame of the connection-management group (CTS or acknowledge).
    function automatic t_out_item cm_result(input t_cfg cfg, input logic [7:0] ctl,
                                            input logic [15:0] size,
                                            input logic [7:0] total,
                                            input logic [17:0] pgn);
        t_out_item r;
        r = '0;
        r.out_kind  = OUT_TX;
        r.tx_can_id = {cfg.reply_priority, 2'b00, PF_CM, cfg.peer_address,
                       cfg.local_address};
        r.payload   = {6'b0, pgn, RESERVED_BYTE, total, size, ctl};
        r.msg_pgn   = pgn;
        r.msg_len   = size;
        return r;
    endfunction

    function automatic t_out_item status_result(input logic st,
                                                input logic [15:0] size,
                                                input logic [17:0] pgn);
        t_out_item r;
        r = '0;
        r.out_kind = OUT_STATUS;
        r.status   = st;
        r.msg_pgn  = pgn;
        r.msg_len  = size;
        return r;
    endfunction

endpackage

@@ rtl/jtp_session.sv @@
`timescale 1ns / 1ps

module jtp_session (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  jtp_pkg::t_in_item i_item,
    input  jtp_pkg::t_cfg     i_cfg,
    output jtp_pkg::t_group   o_grp
);

    typedef enum logic [1:0] {PH_IDLE, PH_RTS, PH_DATA} t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_wait, n_wait;
    logic [17:0] r_pgn, n_pgn;
    logic [15:0] r_size, n_size;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_seq, n_seq;
    logic [15:0] r_left, n_left;

    logic [17:0] rx_pgn;
    logic [7:0]  b0;
    logic        is_rts;
    logic        is_dt;
    logic [16:0] wsum;
    logic [2:0]  nb_base;
    logic [2:0]  nb;
    logic [55:0] chunk;
    logic [15:0] seq_m1;
    logic [15:0] offset;
    logic [15:0] rts_size;
    logic [7:0]  rts_total;
    logic [17:0] rts_pgn;
    jtp_pkg::t_out_item chunk_res;

    always_comb begin
        rx_pgn = i_item.can_id[25:8];
        // PDU1 format: the low byte is a destination address, not part of the PGN.
        if (i_item.can_id[23:16] < jtp_pkg::PF_PDU2_MIN) begin
            rx_pgn[7:0] = 8'h00;
        end
    end

    assign b0     = i_item.frame_data[7:0];
    assign is_rts = (i_item.kind == jtp_pkg::KIND_FRAME) && (r_phase == PH_RTS)
                    && (rx_pgn == jtp_pkg::PGN_CM) && (b0 == jtp_pkg::CTL_RTS);
    assign is_dt  = (i_item.kind == jtp_pkg::KIND_FRAME) && (r_phase == PH_DATA)
                    && (rx_pgn == jtp_pkg::PGN_DT) && (b0 == r_seq);
    assign wsum   = {1'b0, r_wait} + 17'd1;

    assign rts_size  = i_item.frame_data[23:8];
    assign rts_total = i_item.frame_data[31:24];
    assign rts_pgn   = i_item.frame_data[57:40];

    always_comb begin
        if (i_item.frame_len > 4'd8) begin
            nb_base = 3'd7;
        end else if (i_item.frame_len == 4'd0) begin
            nb_base = 3'd0;
        end else begin
            nb_base = 3'(i_item.frame_len - 4'd1);
        end
        if ({13'b0, nb_base} > r_left) begin
            nb = r_left[2:0];
        end else begin
            nb = nb_base;
        end
        for (int i = 0; i < 7; i++) begin
            chunk[8*i +: 8] = (3'(i) < nb) ? i_item.frame_data[8*(i+1) +: 8] : 8'h00;
        end
    end

    // Offset is (sequence - 1) * 7, done as a shift and subtract.
    assign seq_m1 = {8'h00, r_seq} - 16'd1;
    assign offset = (seq_m1 << 3) - seq_m1;

    always_comb begin
        chunk_res              = '0;
        chunk_res.out_kind     = jtp_pkg::OUT_CHUNK;
        chunk_res.payload      = {8'h00, chunk};
        chunk_res.chunk_offset = offset;
        chunk_res.chunk_bytes  = nb;
        chunk_res.msg_pgn      = r_pgn;
        chunk_res.msg_len      = r_size;
    end

    always_comb begin
        o_grp   = '0;
        n_phase = r_phase;
        n_wait  = r_wait;
        n_pgn   = r_pgn;
        n_size  = r_size;
        n_total = r_total;
        n_seq   = r_seq;
        n_left  = r_left;

        if (i_item.kind == jtp_pkg::KIND_START) begin
            n_phase = PH_RTS;
            n_wait  = '0;
            n_pgn   = '0;
            n_size  = '0;
            n_total = '0;
            n_seq   = 8'd1;
            n_left  = '0;
        end else if (i_item.kind == jtp_pkg::KIND_TICK) begin
            if (r_phase != PH_IDLE) begin
                n_wait = wsum[15:0];
                if (wsum >= {1'b0, i_cfg.timeout_ticks}) begin
                    o_grp.cnt    = 2'd1;
                    o_grp.res[0] = jtp_pkg::status_result(jtp_pkg::ST_TIMEOUT,
                                                          r_size, r_pgn);
                    n_phase      = PH_IDLE;
                    n_wait       = '0;
                end
            end
        end else if (is_rts) begin
            n_size  = rts_size;
            n_total = rts_total;
            n_pgn   = rts_pgn;
            n_left  = rts_size;
            n_seq   = 8'd1;
            n_wait  = '0;
            n_phase = PH_DATA;
            o_grp.res[0] = jtp_pkg::cm_result(i_cfg, jtp_pkg::CTL_CTS, rts_size,
                                              rts_total, rts_pgn);
            if (rts_total == 8'd0) begin
                // Empty message: clear to send, acknowledge and finish at once.
                o_grp.cnt    = 2'd3;
                o_grp.res[1] = jtp_pkg::cm_result(i_cfg, jtp_pkg::CTL_ACK, rts_size,
                                                  rts_total, rts_pgn);
                o_grp.res[2] = jtp_pkg::status_result(jtp_pkg::ST_DONE,
                                                      rts_size, rts_pgn);
                n_phase      = PH_IDLE;
            end else begin
                o_grp.cnt = 2'd1;
            end
        end else if (is_dt) begin
            o_grp.res[0] = chunk_res;
            n_left       = r_left - {13'b0, nb};
            n_wait       = '0;
            n_seq        = r_seq + 8'd1;
            if (r_seq == r_total) begin
                o_grp.cnt    = 2'd3;
                o_grp.res[1] = jtp_pkg::cm_result(i_cfg, jtp_pkg::CTL_ACK, r_size,
                                                  r_total, r_pgn);
                o_grp.res[2] = jtp_pkg::status_result(jtp_pkg::ST_DONE,
                                                      r_size, r_pgn);
                n_phase      = PH_IDLE;
            end else begin
                o_grp.cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wait  <= '0;
            r_pgn   <= '0;
            r_size  <= '0;
            r_total <= '0;
            r_seq   <= 8'd1;
            r_left  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_pgn   <= n_pgn;
            r_size  <= n_size;
            r_total <= n_total;
            r_seq   <= n_seq;
            r_left  <= n_left;
        end
    end

endmodule

@@ rtl/jtp_serial.sv @@
`timescale 1ns / 1ps

module jtp_serial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  jtp_pkg::t_group     i_grp,
    input  logic                i_stall,
    output logic                o_valid,
    output jtp_pkg::t_out_item  o_data,
    output logic                o_can_load
);

    jtp_pkg::t_out_item [2:0] r_res;
    logic [1:0]               r_cnt;
    logic                     xfer;

    assign o_valid = (r_cnt != 2'd0);
    assign xfer    = o_valid && !i_stall;

    // A new group may enter once the last queued result leaves.
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && xfer);

    always_comb begin
        o_data      = r_res[0];
        o_data.last = (r_cnt == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_grp.cnt;
        end else if (xfer) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_grp.res;
        end else if (xfer) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

@@ rtl/j1939_tp_rts_cts_receiver.sv @@
`timescale 1ns / 1ps
// Channel   Valid         Stall         Data
// input     i_in_valid    o_in_stall    i_in_data  (kind, can_id, frame_len, frame_data)
// output    o_out_valid   i_out_stall   o_out_data (one result per transfer)
// config    i_cfg_wr_en   -             i_cfg_index, i_cfg_data
//
// An item enters an input register, is decided from there and its results are
// queued in a three-entry output group, where they are registered. One item is taken per
// cycle while the output side keeps up; an item with several results holds the output
// group until each has left, so that port sets the rate.
// Reset is synchronous; it clears the session and the queue and resets the config.
// An output stall holds the current result and any input item that brings results.

module j1939_tp_rts_cts_receiver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  jtp_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jtp_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    jtp_pkg::t_cfg     r_cfg;
    jtp_pkg::t_in_item r_in;
    logic              r_in_valid;
    jtp_pkg::t_group   grp;
    logic              can_load;
    logic              process;
    logic              load;
    logic              in_xfer;

    assign process    = r_in_valid && ((grp.cnt == 2'd0) || can_load);
    assign load       = process && (grp.cnt != 2'd0);
    assign o_in_stall = r_in_valid && !process;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_priority <= jtp_pkg::PRIORITY_RESET;
            r_cfg.local_address  <= '0;
            r_cfg.peer_address   <= '0;
            r_cfg.timeout_ticks  <= jtp_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                jtp_pkg::CFG_REPLY_PRIORITY: r_cfg.reply_priority <= i_cfg_data[2:0];
                jtp_pkg::CFG_LOCAL_ADDRESS:  r_cfg.local_address  <= i_cfg_data[7:0];
                jtp_pkg::CFG_PEER_ADDRESS:   r_cfg.peer_address   <= i_cfg_data[7:0];
                jtp_pkg::CFG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    jtp_session u_session (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (process),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_grp   (grp)
    );

    jtp_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_grp      (grp),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .o_can_load (can_load)
    );

`ifndef ASSERT_OFF
    // An accepted item is held in the input register in the next cycle.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_in_valid)
        else $error("accepted input item not registered");

    // The input side only waits while the output queue still holds results.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output queue");

    // A result that is not the last of its group is followed by the rest of the group.
    a_group_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last) |=> o_out_valid)
        else $error("result group cut short");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import jtp_pkg::*;

    localparam int GAP_MAX        = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_CAP      = 40;

    // Kind code that the block has no use for.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [1:0] {SESS_IDLE, SESS_WAIT_RTS, SESS_DATA} t_sess_phase;
    typedef enum logic {EV_ITEM, EV_CFG} t_ev_kind;

    typedef struct {
        t_ev_kind    ev;
        logic [1:0]  idx;
        logic [15:0] val;
        t_in_item    item;
    } t_bus_event;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Mirror of the receiver's session state and registers.
    t_sess_phase sess_phase;
    logic [16:0] tick_count;
    logic [17:0] sess_pgn;
    logic [15:0] sess_size;
    logic [7:0]  sess_packets;
    logic [7:0]  next_seq;
    logic [15:0] sess_left;
    t_cfg        model_cfg;

    t_out_item   item_results[$];
    t_out_item   due_results[$];
    t_bus_event  bus_events[$];

    int errors = 0;
    int items_sent = 0;
    int directed_items = 0;
    int results_seen = 0;
    int sessions_done = 0;
    int sessions_timed_out = 0;
    int chunks_seen = 0;
    int quiet_cycles = 0;

    int in_gap = 0;
    int settle = 0;
    bit calm_in = 1'b0;
    int out_hold = 0;
    bit calm_out = 1'b0;

    int gen_count = 0;
    int gen_limit = 1000;
    int idle_ticks = 0;

    j1939_tp_rts_cts_receiver DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    function automatic t_out_item cm_reply(input logic [7:0] ctl);
        t_out_item r;
        r = '0;
        r.out_kind  = OUT_TX;
        r.tx_can_id = {model_cfg.reply_priority, 2'b00, PF_CM, model_cfg.peer_address,
                       model_cfg.local_address};
        r.payload   = {6'b0, sess_pgn, RESERVED_BYTE, sess_packets, sess_size, ctl};
        r.msg_pgn   = sess_pgn;
        r.msg_len   = sess_size;
        return r;
    endfunction

    task automatic end_session(input logic st);
        t_out_item r;
        if (st == ST_DONE) begin
            item_results.push_back(cm_reply(CTL_ACK));
        end
        r = '0;
        r.out_kind = OUT_STATUS;
        r.status   = st;
        r.msg_pgn  = sess_pgn;
        r.msg_len  = sess_size;
        item_results.push_back(r);
        sess_phase = SESS_IDLE;
        tick_count = '0;
    endtask

    // Works out the results of one accepted item and queues them as due.
    task automatic advance_session(input t_in_item it);
        logic [17:0] pgn;
        logic [7:0]  b0;
        int unsigned nb;
        logic [63:0] chunk;
        t_out_item   r;
        item_results.delete();
        b0  = it.frame_data[7:0];
        pgn = it.can_id[25:8];
        if (it.can_id[23:16] < PF_PDU2_MIN) begin
            pgn[7:0] = 8'h00;
        end
        case (it.kind)
            KIND_START: begin
                sess_phase   = SESS_WAIT_RTS;
                tick_count   = '0;
                sess_pgn     = '0;
                sess_size    = '0;
                sess_packets = '0;
                next_seq     = 8'd1;
                sess_left    = '0;
            end
            KIND_TICK: begin
                if (sess_phase != SESS_IDLE) begin
                    tick_count = tick_count + 17'd1;
                    if (tick_count >= {1'b0, model_cfg.timeout_ticks}) begin
                        end_session(ST_TIMEOUT);
                    end
                end
            end
            KIND_FRAME: begin
                if (sess_phase == SESS_WAIT_RTS && pgn == PGN_CM && b0 == CTL_RTS) begin
                    sess_size    = it.frame_data[23:8];
                    sess_packets = it.frame_data[31:24];
                    sess_pgn     = it.frame_data[57:40];
                    sess_left    = sess_size;
                    next_seq     = 8'd1;
                    tick_count   = '0;
                    item_results.push_back(cm_reply(CTL_CTS));
                    sess_phase = SESS_DATA;
                    if (sess_packets == 8'd0) begin
                        end_session(ST_DONE);
                    end
                end else if (sess_phase == SESS_DATA && pgn == PGN_DT && b0 == next_seq) begin
                    if (it.frame_len > 4'd8) begin
                        nb = 7;
                    end else if (it.frame_len == 4'd0) begin
                        nb = 0;
                    end else begin
                        nb = it.frame_len - 1;
                    end
                    if (nb > sess_left) begin
                        nb = sess_left;
                    end
                    chunk = '0;
                    for (int k = 0; k < nb; k++) begin
                        chunk[8*k +: 8] = it.frame_data[8*k+8 +: 8];
                    end
                    r = '0;
                    r.out_kind     = OUT_CHUNK;
                    r.payload      = chunk;
                    r.chunk_offset = 16'((int'(next_seq) - 1) * 7);
                    r.chunk_bytes  = 3'(nb);
                    r.msg_pgn      = sess_pgn;
                    r.msg_len      = sess_size;
                    item_results.push_back(r);
                    sess_left  = sess_left - 16'(nb);
                    tick_count = '0;
                    if (next_seq == sess_packets) begin
                        end_session(ST_DONE);
                    end
                    next_seq = next_seq + 8'd1;
                end
            end
            default: ;
        endcase
        if (item_results.size() > 0) begin
            item_results[item_results.size() - 1].last = 1'b1;
        end
        foreach (item_results[i]) begin
            due_results.push_back(item_results[i]);
        end
    endtask

    // Sender: presents queued items, and writes a register only once the block is drained.
    always @(posedge clk) begin : item_driver
        logic        nxt_valid;
        logic        nxt_wr;
        t_in_item    nxt_data;
        logic [1:0]  nxt_idx;
        logic [15:0] nxt_val;
        t_bus_event  head;
        if (rst_n) begin
            nxt_valid = in_valid;
            nxt_data  = in_data;
            nxt_wr    = 1'b0;
            nxt_idx   = cfg_index;
            nxt_val   = cfg_data;
            if (in_valid && !in_stall) begin
                advance_session(in_data);
                items_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (in_gap != 0) begin
                    in_gap--;
                end else if (bus_events.size() != 0) begin
                    head = bus_events[0];
                    if (head.ev == EV_ITEM) begin
                        nxt_valid = 1'b1;
                        nxt_data  = head.item;
                        void'(bus_events.pop_front());
                        in_gap = calm_in ? 0 : $urandom_range(0, GAP_MAX);
                        if ($urandom_range(0, 29) == 0) begin
                            calm_in = !calm_in;
                        end
                    end else if (due_results.size() != 0) begin
                        settle = 0;
                    end else if (settle < SETTLE_CYCLES) begin
                        settle++;
                    end else begin
                        nxt_wr  = 1'b1;
                        nxt_idx = head.idx;
                        nxt_val = head.val;
                        case (head.idx)
                            CFG_REPLY_PRIORITY: model_cfg.reply_priority = head.val[2:0];
                            CFG_LOCAL_ADDRESS:  model_cfg.local_address  = head.val[7:0];
                            CFG_PEER_ADDRESS:   model_cfg.peer_address   = head.val[7:0];
                            CFG_TIMEOUT_TICKS:  model_cfg.timeout_ticks  = head.val;
                            default: ;
                        endcase
                        void'(bus_events.pop_front());
                        settle = 0;
                    end
                end
            end
            in_valid  <= nxt_valid;
            in_data   <= nxt_data;
            cfg_wr_en <= nxt_wr;
            cfg_index <= nxt_idx;
            cfg_data  <= nxt_val;
        end
    end

    // Receiver: checks every result transfer against the oldest due result.
    always @(posedge clk) begin : result_monitor
        t_out_item want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing due", out_data));
                end else begin
                    want = due_results.pop_front();
                    if (out_data.out_kind !== want.out_kind)
                        report_mismatch($sformatf("out_kind %h, due %h",
                                                  out_data.out_kind, want.out_kind));
                    if (out_data.tx_can_id !== want.tx_can_id)
                        report_mismatch($sformatf("tx_can_id %h, due %h",
                                                  out_data.tx_can_id, want.tx_can_id));
                    if (out_data.payload !== want.payload)
                        report_mismatch($sformatf("payload %h, due %h",
                                                  out_data.payload, want.payload));
                    if (out_data.chunk_offset !== want.chunk_offset)
                        report_mismatch($sformatf("chunk_offset %h, due %h",
                                                  out_data.chunk_offset, want.chunk_offset));
                    if (out_data.chunk_bytes !== want.chunk_bytes)
                        report_mismatch($sformatf("chunk_bytes %h, due %h",
                                                  out_data.chunk_bytes, want.chunk_bytes));
                    if (out_data.msg_pgn !== want.msg_pgn)
                        report_mismatch($sformatf("msg_pgn %h, due %h",
                                                  out_data.msg_pgn, want.msg_pgn));
                    if (out_data.msg_len !== want.msg_len)
                        report_mismatch($sformatf("msg_len %h, due %h",
                                                  out_data.msg_len, want.msg_len));
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status %h, due %h",
                                                  out_data.status, want.status));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last %h, due %h",
                                                  out_data.last, want.last));
                    if (want.out_kind == OUT_CHUNK) begin
                        chunks_seen++;
                    end else if (want.out_kind == OUT_STATUS) begin
                        if (want.status == ST_DONE) sessions_done++;
                        else sessions_timed_out++;
                    end
                end
                out_hold = calm_out ? 0 : $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 29) == 0) begin
                    calm_out = !calm_out;
                end
            end else if (out_hold != 0) begin
                out_hold--;
            end
            out_stall <= (out_hold != 0);
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results still due",
                         quiet_cycles, due_results.size());
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_in_item mk_item(input logic [1:0] kind, input logic [28:0] id,
                                         input logic [3:0] len, input logic [63:0] data);
        t_in_item it;
        it.kind       = kind;
        it.can_id     = id;
        it.frame_len  = len;
        it.frame_data = data;
        return it;
    endfunction

    function automatic t_in_item tick_item();
        return mk_item(KIND_TICK, 29'($urandom()), 4'($urandom()), {$urandom(), $urandom()});
    endfunction

    function automatic t_in_item start_item();
        return mk_item(KIND_START, 29'($urandom()), 4'($urandom()), {$urandom(), $urandom()});
    endfunction

    function automatic t_in_item rts_frame(input logic [7:0] ctl, input logic [15:0] size,
                                           input logic [7:0] total, input logic [17:0] pgn);
        return mk_item(KIND_FRAME,
                       {3'($urandom()), 2'b00, PF_CM, 8'($urandom()), 8'($urandom())},
                       4'd8, {6'($urandom()), pgn, 8'($urandom()), total, size, ctl});
    endfunction

    function automatic t_in_item dt_frame(input logic [7:0] seq, input logic [3:0] len);
        return mk_item(KIND_FRAME,
                       {3'($urandom()), 2'b00, PGN_DT[15:8], 8'($urandom()), 8'($urandom())},
                       len, {$urandom(), 24'($urandom()), seq});
    endfunction

    task automatic send(input t_in_item it, input bit counted);
        t_bus_event e;
        e.ev   = EV_ITEM;
        e.idx  = '0;
        e.val  = '0;
        e.item = it;
        bus_events.push_back(e);
        if (counted) gen_count++;
    endtask

    task automatic send_cfg(input logic [1:0] idx, input logic [15:0] val);
        t_bus_event e;
        e.ev   = EV_CFG;
        e.idx  = idx;
        e.val  = val;
        e.item = '0;
        bus_events.push_back(e);
        if (idx == CFG_TIMEOUT_TICKS) gen_limit = val;
    endtask

    // Stray frames and items of the unused kind, plus the odd tick that stays under the timeout.
    task automatic add_noise();
        repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 4))
                0: send(mk_item(KIND_FRAME, 29'($urandom()), 4'($urandom()),
                                {$urandom(), $urandom()}), 1'b0);
                1: send(dt_frame(8'($urandom()), 4'd8), 1'b0);
                2: send(mk_item(KIND_UNUSED, 29'($urandom()), 4'($urandom()),
                                {$urandom(), $urandom()}), 1'b0);
                3: send(rts_frame(CTL_RTS, 16'($urandom()), 8'($urandom()),
                                  18'($urandom())), 1'b0);
                default: begin
                    if (idle_ticks + 1 < gen_limit) begin
                        send(tick_item(), 1'b1);
                        idle_ticks++;
                    end
                end
            endcase
        end
    endtask

    task automatic run_out_clock();
        if (gen_limit <= 40) begin
            repeat (gen_limit) send(tick_item(), 1'b1);
        end
    endtask

    // One session: start, RTS, data frames in order; some are cut short and left to expire.
    task automatic queue_session();
        int total;
        int size;
        int cut;
        bit broken;
        logic [3:0] len;
        total = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
        if ($urandom_range(0, 9) < 2 || total == 0) begin
            size = (total == 0 && $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 65535);
        end else begin
            size = $urandom_range((total - 1) * 7 + 1, total * 7);
        end
        broken = (total > 12) || ($urandom_range(0, 5) == 0);
        cut = broken ? $urandom_range(0, (total < 6) ? total : 6) : -1;
        send(start_item(), 1'b1);
        idle_ticks = 0;
        if ($urandom_range(0, 3) == 0) add_noise();
        if (cut == 0) begin
            run_out_clock();
            return;
        end
        send(rts_frame(CTL_RTS, 16'(size), 8'(total), 18'($urandom())), 1'b1);
        idle_ticks = 0;
        for (int s = 1; s <= total; s++) begin
            if (s == cut) begin
                run_out_clock();
                return;
            end
            if ($urandom_range(0, 3) == 0) add_noise();
            len = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'd8;
            send(dt_frame(8'(s), len), 1'b1);
            idle_ticks = 0;
        end
    endtask

    initial begin
        sess_phase   = SESS_IDLE;
        tick_count   = '0;
        sess_pgn     = '0;
        sess_size    = '0;
        sess_packets = '0;
        next_seq     = 8'd1;
        sess_left    = '0;
        model_cfg.reply_priority = PRIORITY_RESET;
        model_cfg.local_address  = '0;
        model_cfg.peer_address   = '0;
        model_cfg.timeout_ticks  = TIMEOUT_RESET;

        // Directed part. A zero timeout ends a session on its first tick.
        send_cfg(CFG_REPLY_PRIORITY, 16'd0);
        send_cfg(CFG_LOCAL_ADDRESS, 16'hFF);
        send_cfg(CFG_PEER_ADDRESS, 16'h00);
        send_cfg(CFG_TIMEOUT_TICKS, 16'd0);
        send(tick_item(), 1'b1);
        send(rts_frame(CTL_RTS, 16'd7, 8'd1, 18'h0FEFE), 1'b1);
        send(start_item(), 1'b1);
        send(tick_item(), 1'b1);
        send_cfg(CFG_TIMEOUT_TICKS, 16'd1);
        send(start_item(), 1'b1);
        send(tick_item(), 1'b1);

        send_cfg(CFG_REPLY_PRIORITY, 16'd7);
        send_cfg(CFG_LOCAL_ADDRESS, 16'h00);
        send_cfg(CFG_PEER_ADDRESS, 16'hFF);
        send_cfg(CFG_TIMEOUT_TICKS, 16'd3);
        send(start_item(), 1'b1);
        send(dt_frame(8'd1, 4'd8), 1'b1);
        // A broadcast-format id never carries the connection-management group.
        send(mk_item(KIND_FRAME, {3'd7, 2'b00, 8'hF0, PF_CM, 8'h00}, 4'd8,
                     {56'h0, CTL_RTS}), 1'b1);
        send(rts_frame(CTL_CTS, 16'd14, 8'd2, 18'h00100), 1'b1);
        // An RTS announcing no packets completes at once.
        send(rts_frame(CTL_RTS, 16'h0000, 8'd0, 18'h3FFFF), 1'b1);
        send(start_item(), 1'b1);
        send(rts_frame(CTL_RTS, 16'd9, 8'd2, 18'h0FEE1), 1'b1);
        send(dt_frame(8'd2, 4'd8), 1'b1);
        send(rts_frame(CTL_RTS, 16'd5, 8'd1, 18'h00000), 1'b1);
        send(mk_item(KIND_UNUSED, '1, 4'hF, '1), 1'b1);
        send(mk_item(KIND_FRAME, '1, 4'hF, '1), 1'b1);
        send(mk_item(KIND_FRAME, {3'd0, 2'b00, PGN_DT[15:8], 16'h0000}, 4'd8,
                     {56'hFF_FFFF_FFFF_FFFF, 8'd1}), 1'b1);
        send(tick_item(), 1'b1);
        // Overlong length, clipped again by the bytes that remain.
        send(dt_frame(8'd2, 4'd15), 1'b1);
        send(start_item(), 1'b1);
        send(rts_frame(CTL_RTS, 16'd21, 8'd3, 18'($urandom())), 1'b1);
        send(dt_frame(8'd1, 4'd0), 1'b1);
        send(dt_frame(8'd2, 4'd1), 1'b1);
        repeat (3) send(tick_item(), 1'b1);
        directed_items = gen_count;

        // Random part, in four register settings.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_cfg(CFG_REPLY_PRIORITY, 16'($urandom_range(0, 7)));
                    send_cfg(CFG_LOCAL_ADDRESS, 16'($urandom_range(0, 255)));
                    send_cfg(CFG_PEER_ADDRESS, 16'($urandom_range(0, 255)));
                    send_cfg(CFG_TIMEOUT_TICKS, 16'hFFFF);
                end
                1: begin
                    send_cfg(CFG_REPLY_PRIORITY, 16'($urandom_range(0, 7)));
                    send_cfg(CFG_LOCAL_ADDRESS, 16'($urandom_range(0, 255)));
                    send_cfg(CFG_PEER_ADDRESS, 16'($urandom_range(0, 255)));
                    send_cfg(CFG_TIMEOUT_TICKS, 16'($urandom_range(4, 12)));
                end
                2: begin
                    send_cfg(CFG_REPLY_PRIORITY, 16'd7);
                    send_cfg(CFG_LOCAL_ADDRESS, 16'hFF);
                    send_cfg(CFG_PEER_ADDRESS, 16'h00);
                    send_cfg(CFG_TIMEOUT_TICKS, TIMEOUT_RESET);
                end
                default: begin
                    send_cfg(CFG_REPLY_PRIORITY, 16'd0);
                    send_cfg(CFG_LOCAL_ADDRESS, 16'h00);
                    send_cfg(CFG_PEER_ADDRESS, 16'hFF);
                    send_cfg(CFG_TIMEOUT_TICKS, 16'd2);
                end
            endcase
            while (gen_count < directed_items + (p + 1) * 60) queue_session();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (bus_events.size() != 0 || in_valid || due_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_results.size() != 0) begin
            report_mismatch($sformatf("%0d due results never arrived", due_results.size()));
        end
        $display("Run covered %0d input items and %0d checked results over seven settings.",
                 items_sent, results_seen);
        $display("Sessions completed %0d, timed out %0d, chunks %0d, mismatches %0d.",
                 sessions_done, sessions_timed_out, chunks_seen, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/jtp_pkg.sv
rtl/jtp_session.sv
rtl/jtp_serial.sv
rtl/j1939_tp_rts_cts_receiver.sv
tb/sv/tb_top.sv
